// File: rtl/lwc_pkg.sv
package lwc_pkg;

  localparam int MAX_WHEEL_PINS = 64;
  localparam int PIN_IDX_W      = (MAX_WHEEL_PINS > 1) ? $clog2(MAX_WHEEL_PINS) : 1;

  localparam int NUM_WHEELS = 12;
  localparam int NUM_CHI    = 5;
  localparam int PSI_BASE   = 5;
  localparam int MU61_WHEEL = 10;
  localparam int MU37_WHEEL = 11;

  localparam int CMD_W  = 2;
  localparam int SEL_W  = 4;
  localparam int POS_W  = 6;
  localparam int CODE_W = 5;
  localparam int LEN_W  = 6;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 30;

  localparam logic [CMD_W-1:0] CMD_ENCIPHER = 2'd0;
  localparam logic [CMD_W-1:0] CMD_WRITE_PIN = 2'd1;
  localparam logic [CMD_W-1:0] CMD_SET_POS  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_CHI_LENGTHS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PSI_LENGTHS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MU_LENGTHS  = 2'd2;

  localparam logic [29:0] CHI_LENGTHS_RESET = 30'd392812521;
  localparam logic [29:0] PSI_LENGTHS_RESET = 30'd1003961323;
  localparam logic [11:0] MU_LENGTHS_RESET  = 12'd2429;

  typedef logic [LEN_W-1:0] wheel_len_t;

  typedef struct packed {
    logic             pin_we;
    logic             pos_we;
    logic             step;
    logic [POS_W-1:0] idx;
    logic             val;
  } wheel_ctl_t;

endpackage

// File: rtl/lwc_in_if.sv
interface lwc_in_if;
  logic                           valid;
  logic                           ready;
  logic [lwc_pkg::CMD_W-1:0]      cmd;
  logic [lwc_pkg::SEL_W-1:0]      wheel_sel;
  logic [lwc_pkg::POS_W-1:0]      pin_index;
  logic                           pin_value;
  logic [lwc_pkg::CODE_W-1:0]     baudot_in;

  modport source (output valid, cmd, wheel_sel, pin_index, pin_value, baudot_in,
                  input ready);
  modport sink   (input valid, cmd, wheel_sel, pin_index, pin_value, baudot_in,
                  output ready);
endinterface

// File: rtl/lwc_out_if.sv
interface lwc_out_if;
  logic                       valid;
  logic                       ready;
  logic [lwc_pkg::CODE_W-1:0] cipher_out;
  logic [lwc_pkg::CODE_W-1:0] key_used;

  modport source (output valid, cipher_out, key_used, input ready);
  modport sink   (input valid, cipher_out, key_used, output ready);
endinterface

// File: rtl/lwc_cfg_if.sv
interface lwc_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [lwc_pkg::CFG_IDX_W-1:0]  index;
  logic [lwc_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/lorenz_wheel_cipher_top.sv
// Twelve-wheel Lorenz cipher on 5-bit Baudot codes. Accepts one command per clock
// (encipher, write pin, set position) into an input register; when it fires it
// is applied to the wheel state and, for an encipher, cipher_out and key_used
// load into the result register after the input register. Pin and position
// commands give no result. Throughput is one item per cycle, bounded only by the
// result register draining; input ready drops only while an encipher waits behind
// an untaken result. The user must write the length registers over the config
// port only while the block is idle; the block itself does not enforce this.
module lorenz_wheel_cipher_top (
  input  logic      clk,
  input  logic      rst,
  lwc_in_if.sink    in_ch,
  lwc_out_if.source out_ch,
  lwc_cfg_if.sink   cfg_ch
);

  logic                          in_vld;
  logic [lwc_pkg::CMD_W-1:0]     in_cmd;
  logic [lwc_pkg::SEL_W-1:0]     in_sel;
  logic [lwc_pkg::POS_W-1:0]     in_idx;
  logic                          in_val;
  logic [lwc_pkg::CODE_W-1:0]    in_code;

  logic                          out_vld;
  logic [lwc_pkg::CODE_W-1:0]    out_cipher;
  logic [lwc_pkg::CODE_W-1:0]    out_key;

  logic                          is_enc;
  logic                          fire;
  logic                          fire_enc;
  logic [lwc_pkg::CODE_W-1:0]    key;

  lwc_pkg::wheel_len_t wheel_len [lwc_pkg::NUM_WHEELS];
  lwc_pkg::wheel_ctl_t wheel_ctl [lwc_pkg::NUM_WHEELS];
  logic [lwc_pkg::NUM_WHEELS-1:0] pin;

  lwc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_ch    (cfg_ch),
    .wheel_len (wheel_len)
  );

  for (genvar w = 0; w < lwc_pkg::NUM_WHEELS; w++) begin : g_wheel
    lwc_wheel u_wheel (
      .clk     (clk),
      .rst     (rst),
      .len     (wheel_len[w]),
      .ctl     (wheel_ctl[w]),
      .cur_pin (pin[w])
    );
  end

  assign is_enc   = (in_cmd == lwc_pkg::CMD_ENCIPHER);
  // non-encipher commands never wait on the result register
  assign fire     = in_vld && (!is_enc || !out_vld || out_ch.ready);
  assign fire_enc = fire && is_enc;
  assign in_ch.ready = !in_vld || fire;

  always_comb begin
    for (int i = 0; i < lwc_pkg::NUM_CHI; i++)
      key[i] = pin[i] ^ pin[lwc_pkg::PSI_BASE + i];
  end

  // stepping decisions use pins as they stand before any wheel moves
  always_comb begin
    for (int w = 0; w < lwc_pkg::NUM_WHEELS; w++) begin
      wheel_ctl[w].idx    = in_idx;
      wheel_ctl[w].val    = in_val;
      wheel_ctl[w].pin_we = fire && (in_cmd == lwc_pkg::CMD_WRITE_PIN) &&
                            (in_sel == lwc_pkg::SEL_W'(w));
      wheel_ctl[w].pos_we = fire && (in_cmd == lwc_pkg::CMD_SET_POS) &&
                            (in_sel == lwc_pkg::SEL_W'(w));
      if (w < lwc_pkg::PSI_BASE)
        wheel_ctl[w].step = fire_enc;
      else if (w < lwc_pkg::MU61_WHEEL)
        wheel_ctl[w].step = fire_enc && pin[lwc_pkg::MU37_WHEEL];
      else if (w == lwc_pkg::MU61_WHEEL)
        wheel_ctl[w].step = fire_enc;
      else
        wheel_ctl[w].step = fire_enc && pin[lwc_pkg::MU61_WHEEL];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (in_ch.ready) begin
      in_vld <= in_ch.valid;
    end
    if (in_ch.valid && in_ch.ready) begin
      in_cmd  <= in_ch.cmd;
      in_sel  <= in_ch.wheel_sel;
      in_idx  <= in_ch.pin_index;
      in_val  <= in_ch.pin_value;
      in_code <= in_ch.baudot_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (fire_enc) begin
      out_vld <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld <= 1'b0;
    end
    if (fire_enc) begin
      out_cipher <= in_code ^ key;
      out_key    <= key;
    end
  end

  assign out_ch.valid      = out_vld;
  assign out_ch.cipher_out = out_cipher;
  assign out_ch.key_used   = out_key;

  a_rose_from_enc: assert property (@(posedge clk) disable iff (rst)
    $rose(out_vld) |-> $past(fire_enc))
    else $error("result valid rose without an encipher");

  a_cipher_matches: assert property (@(posedge clk) disable iff (rst)
    fire_enc |=> ((out_cipher ^ out_key) == $past(in_code)))
    else $error("cipher xor key differs from input code");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (in_vld && is_enc && out_vld && !out_ch.ready) |-> !fire)
    else $error("pending result overwritten");

  a_one_pos_change: assert property (@(posedge clk) disable iff (rst)
    $countones({wheel_ctl[0].pin_we, wheel_ctl[5].pin_we, wheel_ctl[10].pin_we,
                wheel_ctl[11].pin_we, fire_enc}) <= 1)
    else $error("pin write collided with encipher");

endmodule

// File: rtl/lwc_cfg.sv
module lwc_cfg (
  input  logic                clk,
  input  logic                rst,
  lwc_cfg_if.sink             cfg_ch,
  output lwc_pkg::wheel_len_t wheel_len [lwc_pkg::NUM_WHEELS]
);

  logic [29:0] chi_lengths;
  logic [29:0] psi_lengths;
  logic [11:0] mu_lengths;
  logic        wr;

  assign cfg_ch.ready = 1'b1;
  assign wr = cfg_ch.valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      chi_lengths <= lwc_pkg::CHI_LENGTHS_RESET;
      psi_lengths <= lwc_pkg::PSI_LENGTHS_RESET;
      mu_lengths  <= lwc_pkg::MU_LENGTHS_RESET;
    end else if (wr) begin
      unique case (cfg_ch.index)
        lwc_pkg::CFG_CHI_LENGTHS: chi_lengths <= cfg_ch.data[29:0];
        lwc_pkg::CFG_PSI_LENGTHS: psi_lengths <= cfg_ch.data[29:0];
        lwc_pkg::CFG_MU_LENGTHS:  mu_lengths  <= cfg_ch.data[11:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int i = 0; i < lwc_pkg::NUM_CHI; i++) begin
      wheel_len[i]                     = chi_lengths[6*i +: 6];
      wheel_len[lwc_pkg::PSI_BASE + i] = psi_lengths[6*i +: 6];
    end
    wheel_len[lwc_pkg::MU61_WHEEL] = mu_lengths[5:0];
    wheel_len[lwc_pkg::MU37_WHEEL] = mu_lengths[11:6];
  end

endmodule

// File: rtl/lwc_wheel.sv
module lwc_wheel (
  input  logic                clk,
  input  logic                rst,
  input  lwc_pkg::wheel_len_t len,
  input  lwc_pkg::wheel_ctl_t ctl,
  output logic                cur_pin
);

  logic [lwc_pkg::MAX_WHEEL_PINS-1:0] pins;
  logic [lwc_pkg::POS_W-1:0]          pos;
  logic [lwc_pkg::POS_W-1:0]          pos_next;
  logic [lwc_pkg::POS_W:0]            eff_len;
  logic [lwc_pkg::POS_W:0]            inc;
  logic                               pos_in_store;
  logic                               idx_in_store;

  // zero length acts as one, lengths saturate at the pin count
  always_comb begin
    eff_len = {1'b0, len};
    if (len == '0) eff_len = (lwc_pkg::POS_W+1)'(1);
    if (eff_len > (lwc_pkg::POS_W+1)'(lwc_pkg::MAX_WHEEL_PINS))
      eff_len = (lwc_pkg::POS_W+1)'(lwc_pkg::MAX_WHEEL_PINS);
    inc = {1'b0, pos} + (lwc_pkg::POS_W+1)'(1);
    pos_next = (inc >= eff_len) ? '0 : inc[lwc_pkg::POS_W-1:0];
  end

  assign pos_in_store = {1'b0, pos} < (lwc_pkg::POS_W+1)'(lwc_pkg::MAX_WHEEL_PINS);
  assign idx_in_store = {1'b0, ctl.idx} < (lwc_pkg::POS_W+1)'(lwc_pkg::MAX_WHEEL_PINS);
  assign cur_pin = pos_in_store & pins[pos[lwc_pkg::PIN_IDX_W-1:0]];

  always_ff @(posedge clk) begin
    if (rst) begin
      pins <= '0;
      pos  <= '0;
    end else begin
      if (ctl.pin_we && idx_in_store) pins[ctl.idx[lwc_pkg::PIN_IDX_W-1:0]] <= ctl.val;
      if (ctl.pos_we) begin
        pos <= ctl.idx;
      end else if (ctl.step) begin
        pos <= pos_next;
      end
    end
  end

endmodule
